>>> design/phub_pkg.sv
package phub_pkg;

	localparam int RX_DEPTH = 512;
	localparam int TX_DEPTH = 256;
	localparam int RX_AW = $clog2(RX_DEPTH);
	localparam int TX_AW = $clog2(TX_DEPTH);
	localparam int RX_FW = $clog2(RX_DEPTH + 1);
	localparam int TX_FW = $clog2(TX_DEPTH + 1);

	localparam int BYTE_W = 8;
	localparam int CMD_W = 2;
	localparam int IN_TDATA_W = 24;
	localparam int OUT_TDATA_W = 24;

	typedef logic [BYTE_W-1:0] byte_t;

	localparam byte_t EMPTY_BYTE = 8'hFF;
	localparam byte_t POLL_SET = 8'h01;

	typedef enum logic [CMD_W-1:0] {
		CMD_PIN      = 2'd0,
		CMD_RX_BYTE  = 2'd1,
		CMD_TX_READY = 2'd2,
		CMD_NOP      = 2'd3
	} cmd_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_WR_HOLD  = 3'd1,
		PH_WR_REL   = 3'd2,
		PH_RD_FULL  = 3'd3,
		PH_RD_EMPTY = 3'd4,
		PH_RD_REL   = 3'd5,
		PH_POLL     = 3'd6
	} phase_t;

	typedef enum logic [2:0] {
		DS_ZERO  = 3'd0,
		DS_ONE   = 3'd1,
		DS_LATCH = 3'd2,
		DS_RAM   = 3'd3,
		DS_FF    = 3'd4
	} dsel_t;

	typedef struct packed {
		cmd_t  cmd;
		logic  wr;
		logic  rd;
		logic  pl;
		logic  hold;
		byte_t bus;
		byte_t rx;
	} item_t;

	typedef struct packed {
		logic  drive;
		dsel_t dsel;
		logic  txv;
		logic  rxo;
		logic  txo;
	} res_t;

	function automatic logic [RX_AW-1:0] rx_ptr_next(input logic [RX_AW-1:0] p);
		return (p == RX_AW'(RX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	function automatic logic [TX_AW-1:0] tx_ptr_next(input logic [TX_AW-1:0] p);
		return (p == TX_AW'(TX_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

endpackage

>>> design/phub_ram.sv
module phub_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> design/phub_front.sv
module phub_front (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [phub_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [phub_pkg::CMD_W-1:0]          s_tuser,
	output logic                                q_valid,
	output phub_pkg::item_t                     q_item,
	input  logic                                q_pop
);

	phub_pkg::item_t entry_q [2];
	phub_pkg::item_t item_in;
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;

	always_comb begin
		item_in.cmd  = phub_pkg::cmd_t'(s_tuser);
		item_in.wr   = ~s_tdata[0];
		item_in.rd   = ~s_tdata[1];
		item_in.pl   = ~s_tdata[2];
		item_in.hold = s_tdata[3];
		item_in.bus  = s_tdata[11:4];
		item_in.rx   = s_tdata[19:12];
	end

	assign s_tready = (count_q != 2'd2);
	assign push     = s_tvalid && s_tready;
	assign q_valid  = (count_q != 2'd0);
	assign q_item   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= item_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (q_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			unique case ({push, q_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

>>> design/phub_back.sv
module phub_back (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             q_valid,
	input  phub_pkg::item_t                  q_item,
	output logic                             q_pop,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [phub_pkg::OUT_TDATA_W-1:0] m_tdata
);

	phub_pkg::phase_t              phase_q, phase_nxt;
	phub_pkg::byte_t               latched_q;
	logic [phub_pkg::RX_AW-1:0]    rx_head_q, rx_head_nxt;
	logic [phub_pkg::RX_AW-1:0]    rx_tail_q, rx_tail_nxt;
	logic [phub_pkg::RX_FW-1:0]    rx_fill_q, rx_fill_nxt;
	logic [phub_pkg::TX_AW-1:0]    tx_head_q, tx_head_nxt;
	logic [phub_pkg::TX_AW-1:0]    tx_tail_q, tx_tail_nxt;
	logic [phub_pkg::TX_FW-1:0]    tx_fill_q, tx_fill_nxt;
	phub_pkg::res_t                res, res_s2;
	logic                          valid_s2;
	logic                          advance;
	logic                          rx_we, rx_re, tx_we, tx_re;
	logic                          do_tx_push, do_rx_pop, rd_start;
	logic                          rx_full, rx_nonempty, tx_full, tx_nonempty;
	phub_pkg::dsel_t               start_sel;
	phub_pkg::byte_t               rx_rdata, tx_rdata, dout, txd;

	assign advance     = q_valid && (!valid_s2 || m_tready);
	assign q_pop       = advance;
	assign rx_full     = (rx_fill_q == phub_pkg::RX_FW'(phub_pkg::RX_DEPTH));
	assign rx_nonempty = (rx_fill_q != '0);
	assign tx_full     = (tx_fill_q == phub_pkg::TX_FW'(phub_pkg::TX_DEPTH));
	assign tx_nonempty = (tx_fill_q != '0);

	always_comb begin
		phase_nxt   = phase_q;
		rx_head_nxt = rx_head_q;
		rx_tail_nxt = rx_tail_q;
		rx_fill_nxt = rx_fill_q;
		tx_head_nxt = tx_head_q;
		tx_tail_nxt = tx_tail_q;
		tx_fill_nxt = tx_fill_q;
		res         = '0;
		res.dsel    = phub_pkg::DS_ZERO;
		rx_we       = 1'b0;
		rx_re       = 1'b0;
		tx_we       = 1'b0;
		tx_re       = 1'b0;
		do_tx_push  = 1'b0;
		do_rx_pop   = 1'b0;
		rd_start    = 1'b0;
		start_sel   = phub_pkg::DS_LATCH;

		unique case (q_item.cmd)
			phub_pkg::CMD_PIN: begin
				unique case (phase_q)
					phub_pkg::PH_WR_HOLD: begin
						if (q_item.hold) begin
							do_tx_push = 1'b1;
							phase_nxt  = phub_pkg::PH_WR_REL;
						end else if (!q_item.wr) begin
							phase_nxt = phub_pkg::PH_IDLE;
						end
					end
					phub_pkg::PH_WR_REL, phub_pkg::PH_RD_REL: begin
						if (!q_item.hold) begin
							phase_nxt = phub_pkg::PH_IDLE;
						end
					end
					phub_pkg::PH_RD_FULL, phub_pkg::PH_RD_EMPTY: begin
						if (q_item.hold) begin
							do_rx_pop = (phase_q == phub_pkg::PH_RD_FULL);
							phase_nxt = phub_pkg::PH_RD_REL;
						end else if (!q_item.rd) begin
							phase_nxt = phub_pkg::PH_IDLE;
						end
					end
					phub_pkg::PH_POLL: begin
						if (!q_item.pl) begin
							phase_nxt = phub_pkg::PH_IDLE;
						end
					end
					default: begin
						phase_nxt = phub_pkg::PH_IDLE;
						if (q_item.wr) begin
							if (q_item.hold) begin
								do_tx_push = 1'b1;
								phase_nxt  = phub_pkg::PH_WR_REL;
							end else begin
								phase_nxt = phub_pkg::PH_WR_HOLD;
							end
						end else if (q_item.rd) begin
							rd_start  = 1'b1;
							rx_re     = rx_nonempty;
							start_sel = rx_nonempty ? phub_pkg::DS_RAM : phub_pkg::DS_FF;
							if (q_item.hold) begin
								do_rx_pop = rx_nonempty;
								phase_nxt = phub_pkg::PH_RD_REL;
							end else if (rx_nonempty) begin
								phase_nxt = phub_pkg::PH_RD_FULL;
							end else begin
								phase_nxt = phub_pkg::PH_RD_EMPTY;
							end
						end else if (q_item.pl) begin
							phase_nxt = phub_pkg::PH_POLL;
						end
					end
				endcase
			end
			phub_pkg::CMD_RX_BYTE: begin
				if (rx_full) begin
					res.rxo = 1'b1;
				end else begin
					rx_we       = 1'b1;
					rx_tail_nxt = phub_pkg::rx_ptr_next(rx_tail_q);
					rx_fill_nxt = rx_fill_q + 1'b1;
				end
			end
			phub_pkg::CMD_TX_READY: begin
				if (tx_nonempty) begin
					res.txv     = 1'b1;
					tx_re       = 1'b1;
					tx_head_nxt = phub_pkg::tx_ptr_next(tx_head_q);
					tx_fill_nxt = tx_fill_q - 1'b1;
				end
			end
			phub_pkg::CMD_NOP: begin
			end
			default: begin
			end
		endcase

		if (do_tx_push) begin
			if (tx_full) begin
				res.txo = 1'b1;
			end else begin
				tx_we       = 1'b1;
				tx_tail_nxt = phub_pkg::tx_ptr_next(tx_tail_q);
				tx_fill_nxt = tx_fill_q + 1'b1;
			end
		end
		if (do_rx_pop) begin
			rx_head_nxt = phub_pkg::rx_ptr_next(rx_head_q);
			rx_fill_nxt = rx_fill_q - 1'b1;
		end

		unique case (phase_nxt)
			phub_pkg::PH_RD_FULL, phub_pkg::PH_RD_EMPTY, phub_pkg::PH_RD_REL: begin
				res.drive = 1'b1;
				res.dsel  = rd_start ? start_sel : phub_pkg::DS_LATCH;
			end
			phub_pkg::PH_POLL: begin
				res.drive = 1'b1;
				res.dsel  = (rx_fill_nxt != '0) ? phub_pkg::DS_ONE : phub_pkg::DS_ZERO;
			end
			default: begin
				res.drive = 1'b0;
				res.dsel  = phub_pkg::DS_ZERO;
			end
		endcase
	end

	phub_ram #(
		.WIDTH(phub_pkg::BYTE_W),
		.DEPTH(phub_pkg::RX_DEPTH)
	) u_rx_ram (
		.clk  (clk),
		.we   (advance && rx_we),
		.waddr(rx_tail_q),
		.wdata(q_item.rx),
		.re   (advance && rx_re),
		.raddr(rx_head_q),
		.rdata(rx_rdata)
	);

	phub_ram #(
		.WIDTH(phub_pkg::BYTE_W),
		.DEPTH(phub_pkg::TX_DEPTH)
	) u_tx_ram (
		.clk  (clk),
		.we   (advance && tx_we),
		.waddr(tx_tail_q),
		.wdata(q_item.bus),
		.re   (advance && tx_re),
		.raddr(tx_head_q),
		.rdata(tx_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= phub_pkg::PH_IDLE;
			rx_head_q <= '0;
			rx_tail_q <= '0;
			rx_fill_q <= '0;
			tx_head_q <= '0;
			tx_tail_q <= '0;
			tx_fill_q <= '0;
			valid_s2  <= 1'b0;
			res_s2    <= '0;
			latched_q <= '0;
		end else begin
			if (advance) begin
				phase_q   <= phase_nxt;
				rx_head_q <= rx_head_nxt;
				rx_tail_q <= rx_tail_nxt;
				rx_fill_q <= rx_fill_nxt;
				tx_head_q <= tx_head_nxt;
				tx_tail_q <= tx_tail_nxt;
				tx_fill_q <= tx_fill_nxt;
				res_s2    <= res;
				valid_s2  <= 1'b1;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
			if (valid_s2 && m_tready) begin
				if (res_s2.dsel == phub_pkg::DS_RAM) begin
					latched_q <= rx_rdata;
				end else if (res_s2.dsel == phub_pkg::DS_FF) begin
					latched_q <= phub_pkg::EMPTY_BYTE;
				end
			end
		end
	end

	always_comb begin
		unique case (res_s2.dsel)
			phub_pkg::DS_ONE:   dout = phub_pkg::POLL_SET;
			phub_pkg::DS_LATCH: dout = latched_q;
			phub_pkg::DS_RAM:   dout = rx_rdata;
			phub_pkg::DS_FF:    dout = phub_pkg::EMPTY_BYTE;
			default:            dout = '0;
		endcase
	end

	assign txd      = res_s2.txv ? tx_rdata : '0;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {4'b0, res_s2.txo, res_s2.rxo, txd, res_s2.txv, res_s2.drive, dout};

endmodule

>>> design/parallel_handshake_uart_bridge_core.sv
// Channel  Dir  tdata (low bit up)                                       tuser
// s_*      in   write_strobe_n, read_strobe_n, poll_strobe_n, hold_pin,  cmd
//               bus_data_in, uart_rx_data, zero pad to 24 bits
// m_*      out  bus_data_out, bus_drive, uart_tx_valid, uart_tx_data,    -
//               rx_overflow, tx_overflow, zero pad to 24 bits
//
// One transaction per cycle sustained while m_tready is high; an accepted input enters the queue
// and the back part then executes the queue head into the result register (result register and
// FIFO RAM read load at the same edge).
// Phase, pointers and fill counts update when the back part executes an item.
// Reset clears phase, pointers, fills and the read latch; RAM contents are not cleared.
// The queue absorbs output stalls: s_tready drops once both queue entries are taken.
module parallel_handshake_uart_bridge_core (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// write_strobe_n, read_strobe_n, poll_strobe_n, hold_pin, bus_data_in, uart_rx_data
	input  logic [phub_pkg::IN_TDATA_W-1:0]  s_tdata,
	// cmd
	input  logic [phub_pkg::CMD_W-1:0]       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// bus_data_out, bus_drive, uart_tx_valid, uart_tx_data, rx_overflow, tx_overflow
	output logic [phub_pkg::OUT_TDATA_W-1:0] m_tdata
);

	logic            q_valid;
	logic            q_pop;
	phub_pkg::item_t q_item;

	phub_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop)
	);

	phub_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_item  (q_item),
		.q_pop   (q_pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata)
	);

endmodule
